[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the infrared decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLKD(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[hdl/necir_pkg.sv]
// ----------------------------------------------------------------------------
// necir_pkg
// Types, timing constants and helpers for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

    // Decoder phases
    localparam logic [2:0] PH_NONE    = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_INVALID = 3'd4;

    // Nominal segment lengths in microseconds
    localparam logic [31:0] LEAD_MARK_US    = 32'd9000;
    localparam logic [31:0] LEAD_SPACE_US   = 32'd4500;
    localparam logic [31:0] REPEAT_SPACE_US = 32'd2250;
    localparam logic [31:0] BIT_MARK_US     = 32'd560;
    localparam logic [31:0] ONE_SPACE_US    = 32'd560;
    localparam logic [31:0] ZERO_SPACE_US   = 32'd1680;

    localparam logic [14:0] MARK_MAX   = 15'h7FFF;
    localparam logic [4:0]  FIRST_BIT  = 5'd31;
    localparam logic [8:0]  BYTE_CHECK = 9'd255;

    // Configuration register indexes
    localparam logic [1:0] REG_HIGH_FIRST = 2'd0;
    localparam logic [1:0] REG_MATCH_TOL  = 2'd1;
    localparam logic [1:0] REG_RESET_GAP  = 2'd2;

    localparam logic        RST_HIGH_FIRST = 1'b0;
    localparam logic [11:0] RST_MATCH_TOL  = 12'd300;
    localparam logic [15:0] RST_RESET_GAP  = 16'd20000;

    typedef struct packed {
        logic        high_first;
        logic [11:0] match_tol;
        logic [15:0] reset_gap;
    } t_cfg;

    typedef struct packed {
        logic [31:0] last_time;
        logic [2:0]  phase;
        logic [4:0]  bits_left;
        logic [14:0] mark_len;
        logic [31:0] payload;
        logic        repeat_flag;
    } t_state;

    typedef struct packed {
        logic       frame_valid;
        logic       repeat_seen;
        logic [7:0] address;
        logic [7:0] key_code;
    } t_result;

    // True when a lies within tol of b.
    function automatic logic near_to(logic [31:0] a, logic [31:0] b, logic [11:0] tol);
        logic [31:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d <= {20'd0, tol};
    endfunction

endpackage

[hdl/nec_ir_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// NEC infrared frame decoder fed with timestamped pin edges.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         one pin edge: timestamp and new level
// m_axis    out        one result per edge: flags, address and key code
// apb       in         polarity, match tolerance and restart gap registers
//
// One edge per cycle is sustained while the output is not stalled. A result
// passes through the input register and then the result register around the
// single decode step. The edge in the input register is decoded only when the
// result register is empty or being emptied, so a stalled output holds back at
// most one edge before s_axis_tready falls. Reset is synchronous and active low
// and leaves the decoder waiting for a lead.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nec_ir_frame_decoder_core
    import necir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Edge input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] edge_time_us, [32] pin_level, rest zero
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] address, [15:8] key_code
    output logic [1:0]  m_axis_tuser,   // [0] frame_valid, [1] repeat_seen
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     r_out;
    t_result     n_out;
    logic        r_out_valid;
    logic        r_in_valid;
    logic [31:0] r_in_time;
    logic        r_in_level;
    logic        advance;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_first <= RST_HIGH_FIRST;
            r_cfg.match_tol  <= RST_MATCH_TOL;
            r_cfg.reset_gap  <= RST_RESET_GAP;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_HIGH_FIRST: r_cfg.high_first <= pwdata[0];
                REG_MATCH_TOL:  r_cfg.match_tol  <= pwdata[11:0];
                REG_RESET_GAP:  r_cfg.reset_gap  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HIGH_FIRST: prdata = {31'd0, r_cfg.high_first};
            REG_MATCH_TOL:  prdata = {20'd0, r_cfg.match_tol};
            REG_RESET_GAP:  prdata = {16'd0, r_cfg.reset_gap};
            default:        prdata = '0;
        endcase
    end

    // The edge in the input register is decoded whenever its result can be stored.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_time  <= s_axis_tdata[31:0];
            r_in_level <= s_axis_tdata[32];
        end
    end

    necir_decode u_decode (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_edge_time (r_in_time),
        .i_pin_level (r_in_level),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.last_time   <= '0;
            r_state.phase       <= PH_NONE;
            r_state.bits_left   <= FIRST_BIT;
            r_state.mark_len    <= '0;
            r_state.payload     <= '0;
            r_state.repeat_flag <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.key_code, r_out.address};
    assign m_axis_tuser  = {r_out.repeat_seen, r_out.frame_valid};

    // A repeat code never reports a complete frame.
    `ASSERT_CLKD(a_valid_not_repeat, r_out_valid && r_out.frame_valid |-> !r_out.repeat_seen)
    // The repeat flag is only ever raised together with the done phase.
    `ASSERT_CLKD(a_repeat_done, r_state.repeat_flag |-> r_state.phase == PH_DONE)
    // Bits are only counted down once data reception has begun.
    `ASSERT_CLKD(a_bits_phase, r_state.bits_left != FIRST_BIT |->
        (r_state.phase == PH_DATA || r_state.phase == PH_DONE))
    // A waiting edge with room downstream yields a result on the next cycle.
    `ASSERT_CLKD(a_no_bubble, r_in_valid && (!r_out_valid || m_axis_tready) |=> r_out_valid)

endmodule

[hdl/necir_decode.sv]
// ----------------------------------------------------------------------------
// necir_decode
// Next-state and result logic for one pin edge of the NEC decoder.
// ----------------------------------------------------------------------------
module necir_decode
    import necir_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_state      i_state,
    input  logic [31:0] i_edge_time,
    input  logic        i_pin_level,
    output t_state      o_state,
    output t_result     o_result
);

    logic [31:0] diff;
    logic [31:0] mark_ext;
    logic [8:0]  sum_hi;
    logic [8:0]  sum_lo;
    logic        is_mark;
    logic        lead_mark_ok;
    logic        bit_one_ok;

    assign diff         = i_edge_time - i_state.last_time;
    assign mark_ext     = {17'd0, i_state.mark_len};
    // The segment that ended had the level opposite to the new pin level.
    assign is_mark      = (i_pin_level != i_cfg.high_first);
    assign lead_mark_ok = near_to(mark_ext, LEAD_MARK_US, i_cfg.match_tol);
    assign bit_one_ok   = near_to(mark_ext, BIT_MARK_US, i_cfg.match_tol)
                        && near_to(diff, ONE_SPACE_US, i_cfg.match_tol);

    always_comb begin
        o_state           = i_state;
        o_state.last_time = i_edge_time;

        priority if (diff > {16'd0, i_cfg.reset_gap}) begin
            o_state.phase       = PH_NONE;
            o_state.bits_left   = FIRST_BIT;
            o_state.mark_len    = '0;
            o_state.payload     = '0;
            o_state.repeat_flag = 1'b0;
        end else if (i_state.phase != PH_NONE && i_state.phase != PH_START
                     && i_state.phase != PH_DATA) begin
            // Frame finished or abandoned: wait for a restart gap.
        end else if (is_mark) begin
            o_state.mark_len = (diff > {17'd0, MARK_MAX}) ? MARK_MAX : diff[14:0];
        end else if (i_state.phase == PH_NONE) begin
            priority if (lead_mark_ok && near_to(diff, LEAD_SPACE_US, i_cfg.match_tol)) begin
                o_state.phase = PH_START;
            end else if (lead_mark_ok
                         && near_to(diff, REPEAT_SPACE_US, i_cfg.match_tol)) begin
                o_state.phase       = PH_DONE;
                o_state.repeat_flag = 1'b1;
            end else begin
                o_state.phase = PH_INVALID;
            end
        end else begin
            // Any space that is not a one is taken as a zero.
            o_state.phase = PH_DATA;
            if (bit_one_ok) begin
                o_state.payload[i_state.bits_left] = 1'b1;
            end
            if (i_state.bits_left == '0) begin
                o_state.phase = PH_DONE;
            end else begin
                o_state.bits_left = i_state.bits_left - 5'd1;
            end
        end
    end

    assign sum_hi = {1'b0, o_state.payload[31:24]} + {1'b0, o_state.payload[23:16]};
    assign sum_lo = {1'b0, o_state.payload[15:8]} + {1'b0, o_state.payload[7:0]};

    always_comb begin
        o_result.frame_valid = (diff <= {16'd0, i_cfg.reset_gap}) && is_mark
                             && (o_state.phase == PH_DONE) && !o_state.repeat_flag
                             && (sum_hi == BYTE_CHECK) && (sum_lo == BYTE_CHECK);
        o_result.repeat_seen = o_state.repeat_flag;
        o_result.address     = o_state.payload[31:24];
        o_result.key_code    = o_state.payload[7:0];
    end

endmodule
